@@ rtl/sfc_pkg.sv @@
// ----------------------------------------------------------------------------
// sfc_pkg: shared types and helpers for the sphere frustum cull block
// Plane record, divider control record, saturation and matrix element select.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int NUM_REGS      = 8;

  // One clipping plane: normal (a, b, c) and offset d
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [63:0] d;
  } plane_t;

  // Control that rides along the depth divider
  typedef struct packed {
    logic        vis;
    logic        dodiv;
    logic        neg;
    logic [31:0] den;
  } div_ctl_t;

  // Saturate a 64-bit signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Matrix element idx (column*4 + row) from the packed register file
  function automatic logic signed [31:0] elem(input logic [7:0][63:0] vp,
                                              input logic [3:0] idx);
    logic [63:0] w;
    w = vp[idx[3:1]];
    return idx[0] ? w[63:32] : w[31:0];
  endfunction

endpackage

@@ rtl/sfc_plane_setup.sv @@
// ----------------------------------------------------------------------------
// sfc_plane_setup: frustum plane builder
// Forms the six planes from the matrix, takes the normal length with a
// bit-serial square root and normalizes with a bit-serial divider.
// ----------------------------------------------------------------------------
module sfc_plane_setup #(
  parameter int FRAC_BITS = sfc_pkg::DEF_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [7:0][63:0]       view_proj,
  output logic                   busy,
  output sfc_pkg::plane_t [5:0]  planes
);
  import sfc_pkg::*;

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW);
  localparam logic [31:0] EPS = 32'(((1 << FRAC_BITS) + 5000) / 10000);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_SQ, ST_SQRT, ST_CHK, ST_DINIT, ST_DIV, ST_NEXT
  } state_t;

  state_t             state;
  logic [2:0]         pidx;
  logic [1:0]         j;
  logic [CW-1:0]      cnt;
  logic signed [31:0] coef [4];
  logic [63:0]        acc;
  logic [63:0]        sq_n;
  logic [63:0]        sq_res;
  logic [NW-1:0]      dnum;
  logic [NW-1:0]      dq;
  logic [31:0]        drem;
  logic               dneg;

  logic signed [31:0] load_coef [4];
  logic [1:0]         row;
  logic [63:0]        sq_term;
  logic [63:0]        bitv;
  logic [63:0]        trial;
  logic               sq_ge;
  logic [31:0]        len;
  logic [32:0]        mag;
  logic [32:0]        rem2;
  logic               d_ge;
  logic [NW-1:0]      dq_next;
  logic [63:0]        q_mag;
  logic [63:0]        q_res;

  assign busy = (state != ST_IDLE);
  assign row  = pidx[2:1];
  assign len  = sq_res[31:0];

  // Plane coefficients: row 3 plus or minus the selected row, per column
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      load_coef[k] = sat32(pidx[0]
        ? 64'(elem(view_proj, 4'(k * 4 + 3))) - 64'(elem(view_proj, 4'(k * 4) + {2'b0, row}))
        : 64'(elem(view_proj, 4'(k * 4 + 3))) + 64'(elem(view_proj, 4'(k * 4) + {2'b0, row})));
    end
  end

  // Square of one coefficient, one per cycle
  assign sq_term = 64'(coef[j] * coef[j]);

  // Square root step
  assign bitv  = 64'd1 << (7'd62 - {1'b0, cnt[4:0], 1'b0});
  assign trial = sq_res + bitv;
  assign sq_ge = (sq_n >= trial);

  // Divide step
  assign mag     = coef[j][31] ? (33'd0 - {1'b1, coef[j]}) : {1'b0, coef[j]};
  assign rem2    = {drem, dnum[NW-1]};
  assign d_ge    = (rem2 >= {1'b0, len});
  assign dq_next = {dq[NW-2:0], d_ge};
  assign q_mag   = {{(64-NW){1'b0}}, dq_next};
  assign q_res   = dneg ? (64'd0 - q_mag) : q_mag;

  // Sequence through planes, squares, root and divides
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pidx   <= '0;
      j      <= '0;
      cnt    <= '0;
      planes <= '0;
    end else if (start) begin
      state <= ST_LOAD;
      pidx  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          state <= ST_IDLE;
        end
        ST_LOAD: begin
          for (int k = 0; k < 4; k++) coef[k] <= load_coef[k];
          acc   <= '0;
          j     <= '0;
          state <= ST_SQ;
        end
        ST_SQ: begin
          acc <= acc + sq_term;
          if (j == 2'd2) begin
            sq_n   <= acc + sq_term;
            sq_res <= '0;
            cnt    <= '0;
            state  <= ST_SQRT;
          end else begin
            j <= j + 2'd1;
          end
        end
        ST_SQRT: begin
          if (sq_ge) begin
            sq_n   <= sq_n - trial;
            sq_res <= (sq_res >> 1) + bitv;
          end else begin
            sq_res <= sq_res >> 1;
          end
          cnt <= cnt + 1'b1;
          if (cnt[4:0] == 5'd31) state <= ST_CHK;
        end
        ST_CHK: begin
          if (len > EPS) begin
            j     <= '0;
            state <= ST_DINIT;
          end else begin
            planes[pidx].a <= coef[0];
            planes[pidx].b <= coef[1];
            planes[pidx].c <= coef[2];
            planes[pidx].d <= 64'(coef[3]);
            state          <= ST_NEXT;
          end
        end
        ST_DINIT: begin
          dneg  <= coef[j][31];
          dnum  <= {mag[31:0], {FRAC_BITS{1'b0}}};
          drem  <= '0;
          dq    <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          dnum <= dnum << 1;
          drem <= d_ge ? 32'(rem2 - {1'b0, len}) : rem2[31:0];
          dq   <= dq_next;
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(NW - 1)) begin
            case (j)
              2'd0:    planes[pidx].a <= q_res[31:0];
              2'd1:    planes[pidx].b <= q_res[31:0];
              2'd2:    planes[pidx].c <= q_res[31:0];
              default: planes[pidx].d <= q_res;
            endcase
            if (j == 2'd3) begin
              state <= ST_NEXT;
            end else begin
              j     <= j + 2'd1;
              state <= ST_DINIT;
            end
          end
        end
        ST_NEXT: begin
          if (pidx == 3'd5) begin
            state <= ST_IDLE;
          end else begin
            pidx  <= pidx + 3'd1;
            state <= ST_LOAD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/sfc_depth_div.sv @@
// ----------------------------------------------------------------------------
// sfc_depth_div: pipelined restoring divider for the depth quotient
// One quotient bit per stage; control rides along with each transaction.
// ----------------------------------------------------------------------------
module sfc_depth_div #(
  parameter int FRAC_BITS = sfc_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  sfc_pkg::div_ctl_t           in_ctl,
  input  logic [32+FRAC_BITS-1:0]     in_num,
  output logic                        out_vld,
  output sfc_pkg::div_ctl_t           out_ctl,
  output logic [32+FRAC_BITS-1:0]     out_q
);
  import sfc_pkg::*;

  localparam int NW = 32 + FRAC_BITS;

  logic              vld [NW+1];
  div_ctl_t          ctl [NW+1];
  logic [NW-1:0]     num [NW+1];
  logic [NW-1:0]     quo [NW+1];
  logic [31:0]       rem [NW+1];

  logic [32:0]       rem2 [NW];
  logic              ge   [NW];

  // Compare and subtract for each stage
  always_comb begin
    for (int k = 0; k < NW; k++) begin
      rem2[k] = {rem[k], num[k][NW-1]};
      ge[k]   = (rem2[k] >= {1'b0, ctl[k].den});
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NW; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
      ctl[0] <= in_ctl;
      num[0] <= in_num;
      quo[0] <= '0;
      rem[0] <= '0;
      for (int k = 0; k < NW; k++) begin
        vld[k+1] <= vld[k];
        ctl[k+1] <= ctl[k];
        num[k+1] <= num[k] << 1;
        quo[k+1] <= {quo[k][NW-2:0], ge[k]};
        rem[k+1] <= ge[k] ? 32'(rem2[k] - {1'b0, ctl[k].den}) : rem2[k][31:0];
      end
    end
  end

  assign out_vld = vld[NW];
  assign out_ctl = ctl[NW];
  assign out_q   = quo[NW];

endmodule

@@ rtl/sphere_frustum_cull.sv @@
// ----------------------------------------------------------------------------
// sphere_frustum_cull: bounding sphere test against six frustum planes
// Culls spheres behind any plane and reports clip z over clip w for the rest.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one sphere per transaction:
//   center_x/y/z and sphere_radius, signed/unsigned fixed point.
//   Output channel (out_valid / out_stall) returns visible and ndc_depth,
//   one result transaction for every input transaction, in order.
//   Config channel (cfg_valid / cfg_ready) writes the eight 64-bit matrix
//   registers; cfg_ready is always high. Each write starts a rebuild of the
//   six planes (one square root and, unless the plane is degenerate, four
//   divides per plane, all bit-serial); in_stall is high meanwhile.
//   Throughput: one sphere per cycle while in_stall is low. Each result
//   passes the front stages, the bit-per-stage depth divider and the
//   output register.
//   Reset: matrix and planes clear to zero, the pipeline empties; an empty
//   matrix passes every sphere with depth 0.
//   When the receiver stalls a held result, the whole pipeline freezes and
//   in_stall follows it.
// ----------------------------------------------------------------------------
module sphere_frustum_cull #(
  parameter int FRAC_BITS = sfc_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        sphere_radius,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               visible,
  output logic signed [31:0] ndc_depth,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import sfc_pkg::*;

  localparam int NW = 32 + FRAC_BITS;
  localparam logic signed [31:0] EPS = 32'(((1 << FRAC_BITS) + 5000) / 10000);

  logic [7:0][63:0]   view_proj;
  plane_t [5:0]       planes;
  logic               busy;
  logic               en;
  logic               accept;

  logic               v1, v2, v3;
  logic signed [31:0] s1_x, s1_y, s1_z;
  logic [30:0]        s1_r, s2_r, s3_r;
  logic signed [63:0] fl  [8][3];
  logic signed [63:0] dot [8];

  logic signed [31:0] coefs [8][3];
  logic signed [63:0] offs  [8];
  logic signed [63:0] prod  [8][3];
  logic               cull;
  logic signed [31:0] cz, cw;
  logic [32:0]        cz_mag;
  div_ctl_t           d_ctl;
  logic [NW-1:0]      d_num;

  logic               q_vld;
  div_ctl_t           q_ctl;
  logic [NW-1:0]      q_mag;
  logic signed [31:0] depth;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en || busy;
  assign accept    = in_valid && !in_stall;

  // Hold matrix registers; drop writes past the last index
  always_ff @(posedge clk) begin
    if (rst) begin
      view_proj <= '0;
    end else if (cfg_valid && !cfg_index[3]) begin
      view_proj[cfg_index[2:0]] <= cfg_data;
    end
  end

  sfc_plane_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
    .clk       (clk),
    .rst       (rst),
    .start     (cfg_valid),
    .view_proj (view_proj),
    .busy      (busy),
    .planes    (planes)
  );

  // Gather coefficients: six planes, then matrix rows 2 and 3
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      coefs[i][0] = planes[i].a;
      coefs[i][1] = planes[i].b;
      coefs[i][2] = planes[i].c;
      offs[i]     = planes[i].d;
    end
    for (int k = 0; k < 3; k++) begin
      coefs[6][k] = elem(view_proj, 4'(k * 4 + 2));
      coefs[7][k] = elem(view_proj, 4'(k * 4 + 3));
    end
    offs[6] = 64'(elem(view_proj, 4'd14));
    offs[7] = 64'(elem(view_proj, 4'd15));
  end

  // Products for every row and axis
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      prod[i][0] = coefs[i][0] * s1_x;
      prod[i][1] = coefs[i][1] * s1_y;
      prod[i][2] = coefs[i][2] * s1_z;
    end
  end

  // Cull decision and divider setup
  always_comb begin
    cull = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (dot[i] < -$signed({33'd0, s3_r})) cull = 1'b1;
    end
    cz          = sat32(dot[6]);
    cw          = sat32(dot[7]);
    cz_mag      = cz[31] ? (33'd0 - {1'b1, cz}) : {1'b0, cz};
    d_ctl.vis   = !cull;
    d_ctl.dodiv = (cw > EPS);
    d_ctl.neg   = cz[31];
    d_ctl.den   = cw;
    d_num       = {cz_mag[31:0], {FRAC_BITS{1'b0}}};
  end

  // Advance front stages: input, floored products, dot sums
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1   <= accept;
      s1_x <= center_x;
      s1_y <= center_y;
      s1_z <= center_z;
      s1_r <= sphere_radius;
      v2   <= v1;
      s2_r <= s1_r;
      for (int i = 0; i < 8; i++) begin
        for (int k = 0; k < 3; k++) fl[i][k] <= prod[i][k] >>> FRAC_BITS;
      end
      v3   <= v2;
      s3_r <= s2_r;
      for (int i = 0; i < 8; i++) dot[i] <= fl[i][0] + fl[i][1] + fl[i][2] + offs[i];
    end
  end

  sfc_depth_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v3),
    .in_ctl  (d_ctl),
    .in_num  (d_num),
    .out_vld (q_vld),
    .out_ctl (q_ctl),
    .out_q   (q_mag)
  );

  // Apply sign and saturate the quotient
  always_comb begin
    if (q_ctl.neg) begin
      if (q_mag > NW'(33'h0_8000_0000)) depth = -32'sh8000_0000;
      else depth = 32'(0 - q_mag[31:0]);
    end else begin
      if (q_mag > NW'(32'h7FFF_FFFF)) depth = 32'sh7FFF_FFFF;
      else depth = q_mag[31:0];
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q_vld;
      visible   <= q_ctl.vis;
      ndc_depth <= (q_ctl.vis && q_ctl.dodiv) ? depth : 32'sd0;
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for sphere_frustum_cull
// Loads view-projection matrices over the config channel, streams spheres
// under random gaps and back-pressure, and checks visible / ndc_depth against
// an in-bench fixed-point model of the plane extraction and cull test.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfc_pkg::*;

  localparam int          FRAC         = DEF_FRAC_BITS;
  localparam longint      EPS_Q        = ((64'sd1 <<< FRAC) + 5000) / 10000;
  localparam int          SETTLE_CYC   = FRAC + 48;
  localparam int          WDOG_LIMIT   = 20000;
  localparam int          RAND_PHASES  = 6;
  localparam int          PHASE_ITEMS  = 80;
  localparam logic [3:0]  CFG_IDX_VOID = 4'd9;
  localparam logic [31:0] Q_ONE        = 32'h0001_0000;
  localparam logic [31:0] S_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN        = 32'h8000_0000;
  localparam logic [30:0] R_MAX        = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    MAT_ZERO, MAT_PERSP, MAT_TINY, MAT_MAXPOS, MAT_MINNEG, MAT_RAND_FULL, MAT_RAND_SMALL
  } mat_kind_t;

  typedef struct packed {
    mat_kind_t   mat;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [30:0] r;
    logic        fixed;
    logic        vis;
    logic [31:0] depth;
  } probe_row_t;

  typedef struct {
    logic        vis;
    logic [31:0] depth;
  } cull_result_t;

  localparam int N_PROBES = 22;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] center_x = '0;
  logic signed [31:0] center_y = '0;
  logic signed [31:0] center_z = '0;
  logic [30:0]        sphere_radius = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               visible;
  logic signed [31:0] ndc_depth;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [3:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;

  // typed expectation riding along with the sphere transaction
  logic               tag_fixed = 1'b0;
  logic               tag_vis = 1'b0;
  logic [31:0]        tag_depth = '0;

  logic [63:0]        vp_shadow [NUM_REGS];
  longint signed      plane_set [6][4];
  logic [31:0]        mat_next [16];
  cull_result_t       pending_cull_q [$];
  probe_row_t         probe_tab [N_PROBES];
  int                 gap_pct = 18;
  int                 err_cnt = 0;
  int                 quiet_cyc = 0;

  sphere_frustum_cull i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .sphere_radius(sphere_radius),
    .out_valid(out_valid), .out_stall(out_stall),
    .visible(visible), .ndc_depth(ndc_depth),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint signed clamp_word(input longint signed v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic longint signed mat_el(input int i);
    logic [63:0] w;
    w = vp_shadow[i >> 1];
    return (i & 1) ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned probe;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= res + probe) begin
        n = n - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // rebuild the six planes from the shadow matrix
  function automatic void refresh_planes();
    int row;
    longint signed w;
    longint signed e;
    longint unsigned sum;
    longint signed len;
    for (int k = 0; k < 6; k++) begin
      row = (k >> 1) % 3;
      sum = 0;
      for (int j = 0; j < 4; j++) begin
        w = mat_el(j * 4 + 3);
        e = mat_el(j * 4 + row);
        plane_set[k][j] = clamp_word((k & 1) ? w - e : w + e);
      end
      for (int j = 0; j < 3; j++) sum = sum + longint'(plane_set[k][j] * plane_set[k][j]);
      len = longint'(int_sqrt(sum));
      // degenerate planes stay unnormalized
      if (len > EPS_Q) begin
        for (int j = 0; j < 4; j++) plane_set[k][j] = (plane_set[k][j] <<< FRAC) / len;
      end
    end
  endfunction

  function automatic longint signed plane_dot(input longint signed p0, p1, p2, p3,
                                              input longint signed x, y, z);
    return ((p0 * x) >>> FRAC) + ((p1 * y) >>> FRAC) + ((p2 * z) >>> FRAC) + p3;
  endfunction

  function automatic cull_result_t cull_sphere(input logic [31:0] xr, yr, zr,
                                               input logic [30:0] rr);
    cull_result_t res;
    longint signed x, y, z, r, cz, cw;
    x = longint'($signed(xr));
    y = longint'($signed(yr));
    z = longint'($signed(zr));
    r = longint'({33'd0, rr});
    res.vis = 1'b1;
    res.depth = '0;
    for (int k = 0; k < 6; k++) begin
      if (plane_dot(plane_set[k][0], plane_set[k][1], plane_set[k][2], plane_set[k][3],
                    x, y, z) < -r) res.vis = 1'b0;
    end
    if (res.vis) begin
      cz = clamp_word(plane_dot(mat_el(2), mat_el(6), mat_el(10), mat_el(14), x, y, z));
      cw = clamp_word(plane_dot(mat_el(3), mat_el(7), mat_el(11), mat_el(15), x, y, z));
      if (cw > EPS_Q) res.depth = 32'(clamp_word((cz <<< FRAC) / cw));
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // track config writes, predict accepted spheres, check results, watchdog
  always @(posedge clk) begin
    bit           moved;
    cull_result_t want_res;
    moved = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        if (cfg_index < NUM_REGS) begin
          vp_shadow[cfg_index] = cfg_data;
          refresh_planes();
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        if (tag_fixed) begin
          want_res.vis   = tag_vis;
          want_res.depth = tag_depth;
        end else begin
          want_res = cull_sphere(center_x, center_y, center_z, sphere_radius);
        end
        pending_cull_q = {pending_cull_q, want_res};
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_cull_q.size() == 0) begin
          report_mismatch("result with nothing outstanding");
        end else begin
          if (visible !== pending_cull_q[0].vis)
            report_mismatch($sformatf("visible %b, want %b", visible,
                                      pending_cull_q[0].vis));
          if (ndc_depth !== pending_cull_q[0].depth)
            report_mismatch($sformatf("ndc_depth %h, want %h", ndc_depth,
                                      pending_cull_q[0].depth));
          void'(pending_cull_q.pop_front());
        end
      end
      quiet_cyc <= moved ? 0 : quiet_cyc + 1;
      if (quiet_cyc >= WDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // random back-pressure on the result side
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < gap_pct);
  end

  task automatic write_reg(input logic [3:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // hold input off until every outstanding result is back, then settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_cull_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic build_matrix(input mat_kind_t kind, input bit jitter);
    for (int i = 0; i < 16; i++) mat_next[i] = '0;
    case (kind)
      MAT_PERSP: begin
        mat_next[0]  = Q_ONE;
        mat_next[5]  = Q_ONE;
        mat_next[10] = -Q_ONE;
        mat_next[11] = -Q_ONE;
        mat_next[14] = -(Q_ONE / 5);
        if (jitter) begin
          for (int i = 0; i < 16; i++) mat_next[i] += $urandom_range(0, 8191) - 4096;
        end
      end
      MAT_TINY: begin
        for (int i = 0; i < 16; i++)
          mat_next[i] = jitter ? $urandom_range(0, 6) - 3 : (i % 7) - 3;
      end
      MAT_MAXPOS: for (int i = 0; i < 16; i++) mat_next[i] = S_MAX;
      MAT_MINNEG: for (int i = 0; i < 16; i++) mat_next[i] = S_MIN;
      MAT_RAND_FULL: for (int i = 0; i < 16; i++) mat_next[i] = $urandom;
      MAT_RAND_SMALL: begin
        for (int i = 0; i < 16; i++) mat_next[i] = $urandom_range(0, 8 << FRAC) - (4 << FRAC);
      end
      default: ;
    endcase
  endtask

  task automatic load_matrix(input mat_kind_t kind, input bit jitter);
    drain();
    build_matrix(kind, jitter);
    for (int i = 0; i < NUM_REGS; i++) write_reg(i[3:0], {mat_next[2*i+1], mat_next[2*i]});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sphere(input logic [31:0] x, y, z, input logic [30:0] r,
                             input logic fixed, input logic vis, input logic [31:0] depth);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    center_x      <= x;
    center_y      <= y;
    center_z      <= z;
    sphere_radius <= r;
    tag_fixed     <= fixed;
    tag_vis       <= vis;
    tag_depth     <= depth;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    mat_kind_t cur_mat;
    mat_kind_t pick;
    logic [31:0] x, y, z;
    logic [30:0] r;

    for (int i = 0; i < NUM_REGS; i++) vp_shadow[i] = '0;
    refresh_planes();

    // zero matrix rows: everything passes with depth 0
    probe_tab = '{
      '{MAT_ZERO, S_MAX, S_MAX, S_MAX, R_MAX, 1'b1, 1'b1, 32'd0},
      '{MAT_ZERO, S_MIN, S_MIN, S_MIN, 31'd0, 1'b1, 1'b1, 32'd0},
      '{MAT_ZERO, 32'd0, 32'd0, 32'd0, 31'd0, 1'b1, 1'b1, 32'd0},
      '{MAT_ZERO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd1, 1'b1, 1'b1, 32'd0},
      '{MAT_ZERO, S_MAX, S_MIN, 32'd0, R_MAX, 1'b1, 1'b1, 32'd0},
      // perspective: in front, behind, large radius, off to the sides, w at zero
      '{MAT_PERSP, 32'd0, 32'd0, -(5 * Q_ONE), 31'd0, 1'b0, 1'b0, 32'd0},
      '{MAT_PERSP, 32'd0, 32'd0, 5 * Q_ONE, 31'd0, 1'b0, 1'b0, 32'd0},
      '{MAT_PERSP, 32'd0, 32'd0, 5 * Q_ONE, 31'(10 * Q_ONE), 1'b0, 1'b0, 32'd0},
      '{MAT_PERSP, 100 * Q_ONE, 32'd0, -(5 * Q_ONE), 31'd0, 1'b0, 1'b0, 32'd0},
      '{MAT_PERSP, -(100 * Q_ONE), 32'd0, -(5 * Q_ONE), 31'(Q_ONE), 1'b0, 1'b0, 32'd0},
      '{MAT_PERSP, 32'd0, 100 * Q_ONE, -(5 * Q_ONE), 31'(200 * Q_ONE), 1'b0, 1'b0, 32'd0},
      '{MAT_PERSP, 32'd0, 32'd0, 32'd0, 31'(Q_ONE), 1'b0, 1'b0, 32'd0},
      '{MAT_PERSP, 32'd0, 32'd0, -(Q_ONE / 10), 31'd0, 1'b0, 1'b0, 32'd0},
      '{MAT_PERSP, S_MAX, S_MAX, S_MAX, R_MAX, 1'b0, 1'b0, 32'd0},
      '{MAT_PERSP, S_MIN, S_MIN, S_MIN, 31'd0, 1'b0, 1'b0, 32'd0},
      // degenerate planes used unnormalized
      '{MAT_TINY, Q_ONE / 2, -(Q_ONE / 2), Q_ONE, 31'd0, 1'b0, 1'b0, 32'd0},
      '{MAT_TINY, S_MAX, S_MIN, S_MAX, 31'd0, 1'b0, 1'b0, 32'd0},
      '{MAT_TINY, 32'd3, -32'd5, 32'd7, 31'd2, 1'b0, 1'b0, 32'd0},
      // saturated matrices
      '{MAT_MAXPOS, S_MAX, S_MAX, S_MAX, R_MAX, 1'b0, 1'b0, 32'd0},
      '{MAT_MAXPOS, S_MIN, S_MIN, S_MIN, 31'd0, 1'b0, 1'b0, 32'd0},
      '{MAT_MINNEG, S_MAX, S_MIN, 32'd0, R_MAX, 1'b0, 1'b0, 32'd0},
      '{MAT_MINNEG, S_MIN, S_MIN, S_MIN, 31'd0, 1'b0, 1'b0, 32'd0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // write beyond the register file must leave the matrix empty
    write_reg(CFG_IDX_VOID, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    cur_mat = MAT_ZERO;

    foreach (probe_tab[i]) begin
      if (probe_tab[i].mat != cur_mat) begin
        load_matrix(probe_tab[i].mat, 1'b0);
        cur_mat = probe_tab[i].mat;
      end
      send_sphere(probe_tab[i].x, probe_tab[i].y, probe_tab[i].z, probe_tab[i].r,
                  probe_tab[i].fixed, probe_tab[i].vis, probe_tab[i].depth);
    end

    // random phases over fresh matrices; one phase runs with no gaps at all
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      pick = (ph % 3 == 0) ? MAT_PERSP : mat_kind_t'($urandom_range(1, 6));
      load_matrix(pick, 1'b1);
      gap_pct = (ph == 2) ? 0 : 18;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          x = $urandom_range(0, 64 << FRAC) - (32 << FRAC);
          y = $urandom_range(0, 64 << FRAC) - (32 << FRAC);
          z = $urandom_range(0, 48 << FRAC) - (40 << FRAC);
          r = 31'($urandom_range(0, 4 << FRAC));
        end else begin
          x = $urandom;
          y = $urandom;
          z = $urandom;
          r = 31'($urandom);
        end
        send_sphere(x, y, z, r, 1'b0, 1'b0, 32'd0);
        if (n == PHASE_ITEMS / 2 && ph == 1) drain();
      end
    end

    gap_pct = 18;
    drain();
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sphere_frustum_cull.f @@
rtl/sfc_pkg.sv
rtl/sfc_plane_setup.sv
rtl/sfc_depth_div.sv
rtl/sphere_frustum_cull.sv
tb/tb.sv
